>>> src/tks_pkg.sv
package tks_pkg;

    localparam int DEF_K_MAX     = 16;
    localparam int DEF_VOCAB_MAX = 131072;

    localparam int SCORE_W     = 32;
    localparam int IDX_W       = 17;
    localparam int COUNT_W     = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BEAM_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAM_COUNT = 1'b1;

    localparam logic [COUNT_W-1:0] BEAM_COUNT_RST = 5'd1;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

>>> src/tks_score_if.sv
interface tks_score_if;
    import tks_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] score;
    logic                      last_score;

    modport source (output valid, output score, output last_score, input ready);
    modport sink   (input valid, input score, input last_score, output ready);
endinterface

>>> src/tks_token_if.sv
interface tks_token_if;
    import tks_pkg::*;

    logic                      valid;
    logic                      ready;
    logic        [IDX_W-1:0]   token_index;
    logic signed [SCORE_W-1:0] token_score;
    logic                      last_result;

    modport source (output valid, output token_index, output token_score,
                    output last_result, input ready);
    modport sink   (input valid, input token_index, input token_score,
                    input last_result, output ready);
endinterface

>>> src/tks_queue.sv
module tks_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output tks_pkg::t_q_flags  o_flags
);
    import tks_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_data        = r_mem[r_rd];
    assign o_flags.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_flags.empty = (r_cnt == '0);

endmodule

>>> src/tks_front.sv
module tks_front #(
    parameter int VOCAB_MAX = tks_pkg::DEF_VOCAB_MAX
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tks_score_if.sink             i_score_ch,
    input  tks_pkg::t_q_flags     i_flags,
    output logic                  o_push,
    output logic [tks_pkg::SCORE_W+$clog2(VOCAB_MAX+1)+1:0] o_entry
);
    import tks_pkg::*;

    localparam int CNT_W = $clog2(VOCAB_MAX + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             keep;

    assign i_score_ch.ready = !i_flags.full;
    assign o_push           = i_score_ch.valid && !i_flags.full;

    // scores past the vocabulary limit are still queued, flagged not kept, so only their last mark counts
    assign keep    = (r_cnt < CNT_W'(VOCAB_MAX));
    assign o_entry = {i_score_ch.score, r_cnt, keep, i_score_ch.last_score};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_push) begin
            if (i_score_ch.last_score) begin
                r_cnt <= '0;
            end else if (keep) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule

>>> src/tks_back.sv
module tks_back #(
    parameter int K_MAX     = tks_pkg::DEF_K_MAX,
    parameter int VOCAB_MAX = tks_pkg::DEF_VOCAB_MAX
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tks_pkg::SCORE_W+$clog2(VOCAB_MAX+1)+1:0] i_entry,
    input  tks_pkg::t_q_flags           i_flags,
    output logic                        o_pop,
    input  logic                        i_beam_mode,
    input  logic [tks_pkg::COUNT_W-1:0] i_beam_count,
    tks_token_if.source                 o_token_ch
);
    import tks_pkg::*;

    localparam int CNT_W  = $clog2(VOCAB_MAX + 1);
    localparam int ENT_W  = SCORE_W + CNT_W + 2;
    localparam int FILL_W = $clog2(K_MAX + 1);

    logic signed [SCORE_W-1:0] e_score;
    logic        [CNT_W-1:0]   e_idx;
    logic                      e_keep;
    logic                      e_last;

    logic signed [SCORE_W-1:0] r_best_score [K_MAX];
    logic        [IDX_W-1:0]   r_best_idx   [K_MAX];
    logic signed [SCORE_W-1:0] r_arr        [K_MAX];
    logic signed [SCORE_W-1:0] n_best_score [K_MAX];
    logic        [IDX_W-1:0]   n_best_idx   [K_MAX];
    logic        [K_MAX-1:0]   ge;

    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_left;
    logic [FILL_W-1:0] r_arr_pos;
    logic              r_emit;
    logic              r_from_arr;

    logic                      r_out_valid;
    logic        [IDX_W-1:0]   r_out_idx;
    logic signed [SCORE_W-1:0] r_out_score;
    logic                      r_out_last;

    logic [FILL_W-1:0] k_eff;
    logic [CNT_W-1:0]  n_total;
    logic              beam_small;
    logic              emit_go;
    logic [IDX_W-1:0]  new_idx;

    assign e_score = i_entry[ENT_W-1 -: SCORE_W];
    assign e_idx   = i_entry[CNT_W+1:2];
    assign e_keep  = i_entry[1];
    assign e_last  = i_entry[0];
    assign new_idx = IDX_W'(e_idx);

    assign o_pop   = !i_flags.empty && !r_emit;
    assign emit_go = r_emit && (!r_out_valid || o_token_ch.ready);

    always_comb begin
        if (i_beam_count == '0) begin
            k_eff = FILL_W'(1);
        end else if (32'(i_beam_count) > 32'(K_MAX)) begin
            k_eff = FILL_W'(K_MAX);
        end else begin
            k_eff = FILL_W'(i_beam_count);
        end
    end

    assign n_total    = e_idx + CNT_W'(e_keep);
    assign beam_small = (32'(n_total) <= 32'(k_eff));

    // insertion: a cell holds if its score is at least the new one, the first cell
    // that does not takes the new word, and those below it move down by one
    always_comb begin
        for (int j = 0; j < K_MAX; j++) begin
            ge[j] = (32'(j) < 32'(r_fill)) && (r_best_score[j] >= e_score);
        end
        if (ge[0]) begin
            n_best_score[0] = r_best_score[0];
            n_best_idx[0]   = r_best_idx[0];
        end else begin
            n_best_score[0] = e_score;
            n_best_idx[0]   = new_idx;
        end
        for (int j = 1; j < K_MAX; j++) begin
            if (ge[j]) begin
                n_best_score[j] = r_best_score[j];
                n_best_idx[j]   = r_best_idx[j];
            end else if (ge[j-1]) begin
                n_best_score[j] = e_score;
                n_best_idx[j]   = new_idx;
            end else begin
                n_best_score[j] = r_best_score[j-1];
                n_best_idx[j]   = r_best_idx[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_left      <= '0;
            r_arr_pos   <= '0;
            r_emit      <= 1'b0;
            r_from_arr  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (e_keep && r_fill != FILL_W'(K_MAX)) begin
                    r_fill <= r_fill + 1'b1;
                end
                if (e_last) begin
                    r_emit    <= 1'b1;
                    r_arr_pos <= '0;
                    if (!i_beam_mode) begin
                        r_left     <= FILL_W'(1);
                        r_from_arr <= 1'b0;
                    end else if (beam_small) begin
                        // short vocabulary: everything, in index order
                        r_left     <= FILL_W'(n_total);
                        r_from_arr <= 1'b1;
                    end else begin
                        r_left     <= k_eff;
                        r_from_arr <= 1'b0;
                    end
                end
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
                r_left      <= r_left - 1'b1;
                r_arr_pos   <= r_arr_pos + 1'b1;
                if (r_left == FILL_W'(1)) begin
                    r_emit <= 1'b0;
                    r_fill <= '0;
                end
            end else if (o_token_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && e_keep) begin
            r_best_score <= n_best_score;
            r_best_idx   <= n_best_idx;
            for (int j = 0; j < K_MAX; j++) begin
                if (32'(e_idx) == 32'(j)) begin
                    r_arr[j] <= e_score;
                end
            end
        end
        if (emit_go) begin
            r_out_last <= (r_left == FILL_W'(1));
            if (r_from_arr) begin
                r_out_idx   <= IDX_W'(r_arr_pos);
                r_out_score <= r_arr[0];
                for (int j = 0; j < K_MAX - 1; j++) begin
                    r_arr[j] <= r_arr[j+1];
                end
            end else begin
                r_out_idx   <= r_best_idx[0];
                r_out_score <= r_best_score[0];
                for (int j = 0; j < K_MAX - 1; j++) begin
                    r_best_score[j] <= r_best_score[j+1];
                    r_best_idx[j]   <= r_best_idx[j+1];
                end
            end
        end
    end

    assign o_token_ch.valid       = r_out_valid;
    assign o_token_ch.token_index = r_out_idx;
    assign o_token_ch.token_score = r_out_score;
    assign o_token_ch.last_result = r_out_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(K_MAX))
        else $error("best list fill beyond capacity");

    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> (r_left != '0))
        else $error("emitting with nothing left to send");

    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_emit) |-> (r_out_valid && r_out_last))
        else $error("selection ended without a final word");

endmodule

>>> src/topk_token_selector.sv
// Streaming top-k / argmax token selector.
// i_score_ch takes one signed Q16.16 score per word, numbered from 0 within a
// vocabulary; last_score closes the vocabulary. o_token_ch returns the
// selection: in beam mode the beam_count best tokens, highest score first
// (ties: lower index first), or the whole vocabulary in index order if it is
// no longer than beam_count; in greedy mode the single best token.
// last_result marks the final word of each selection.
// Configuration (i_cfg_we, i_cfg_index, i_cfg_data): index 0 beam_mode,
// index 1 beam_count; write only while the block is idle.
// Throughput: one score per cycle until the queue fills during a selection.
// The insertion cells take one score a cycle and stop taking scores while a
// selection is shifted out, one word per cycle while the receiver is ready;
// a four-word queue ahead of the cells keeps i_score_ch ready meanwhile.
// The last score passes the queue, r_emit and then the output register.
// A stalled receiver holds the output word and, once the queue fills, drops
// i_score_ch.ready. Reset clears the counters and the queue, greedy mode,
// beam_count 1.
module topk_token_selector #(
    parameter int K_MAX     = tks_pkg::DEF_K_MAX,
    parameter int VOCAB_MAX = tks_pkg::DEF_VOCAB_MAX
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tks_score_if.sink                      i_score_ch,
    tks_token_if.source                    o_token_ch,
    input  logic                           i_cfg_we,
    input  logic [tks_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tks_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tks_pkg::*;

    localparam int CNT_W = $clog2(VOCAB_MAX + 1);
    localparam int ENT_W = SCORE_W + CNT_W + 2;

    logic               r_beam_mode;
    logic [COUNT_W-1:0] r_beam_count;

    logic             push;
    logic             pop;
    logic [ENT_W-1:0] push_entry;
    logic [ENT_W-1:0] head_entry;
    t_q_flags         q_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam_mode  <= 1'b0;
            r_beam_count <= BEAM_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BEAM_MODE:  r_beam_mode  <= i_cfg_data[0];
                CFG_BEAM_COUNT: r_beam_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    tks_front #(
        .VOCAB_MAX (VOCAB_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_score_ch (i_score_ch),
        .i_flags    (q_flags),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    tks_queue #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (head_entry),
        .o_flags (q_flags)
    );

    tks_back #(
        .K_MAX     (K_MAX),
        .VOCAB_MAX (VOCAB_MAX)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_entry      (head_entry),
        .i_flags      (q_flags),
        .o_pop        (pop),
        .i_beam_mode  (r_beam_mode),
        .i_beam_count (r_beam_count),
        .o_token_ch   (o_token_ch)
    );

endmodule

>>> tb/tks_selection_checker.sv
`timescale 1ns / 1ps

module tks_selection_checker
    import tks_pkg::*;
#(
    parameter int K_MAX     = DEF_K_MAX,
    parameter int VOCAB_MAX = DEF_VOCAB_MAX
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tks_score_if                  i_score_ch,
    tks_token_if                  i_token_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int unsigned           o_errors,
    output int unsigned           o_pending,
    output int unsigned           o_words
);

    typedef struct packed {
        logic [IDX_W-1:0]          tok_idx;
        logic signed [SCORE_W-1:0] tok_score;
        logic                      tok_last;
    } t_token_word;

    // selector state as the block should hold it
    logic signed [SCORE_W-1:0] top_scores   [K_MAX];
    logic [IDX_W-1:0]          top_indices  [K_MAX];
    logic signed [SCORE_W-1:0] first_scores [K_MAX];
    int                        top_fill;
    int                        vocab_len;
    logic                      beam_on;
    logic [COUNT_W-1:0]        beam_k;

    t_token_word expected_words[$];
    int unsigned mismatches = 0;
    int unsigned words_seen = 0;

    function automatic void queue_word(input int idx, input logic signed [SCORE_W-1:0] s,
                                       input logic is_last);
        t_token_word w;
        w.tok_idx   = IDX_W'(idx);
        w.tok_score = s;
        w.tok_last  = is_last;
        expected_words = {expected_words, w};
    endfunction

    // insert one score into the sorted list; on the last mark, queue the selection
    function automatic void take_score(input logic signed [SCORE_W-1:0] s,
                                       input logic is_last);
        int pos;
        int slot;
        int n;
        int k;
        if (vocab_len < VOCAB_MAX) begin
            if (vocab_len < K_MAX)
                first_scores[vocab_len] = s;
            pos = top_fill;
            // strict compare: an equal score stays behind the earlier one
            while (pos > 0 && top_scores[pos-1] < s)
                pos--;
            if (pos < K_MAX) begin
                slot = (top_fill < K_MAX) ? top_fill : K_MAX - 1;
                while (slot > pos) begin
                    top_scores[slot]  = top_scores[slot-1];
                    top_indices[slot] = top_indices[slot-1];
                    slot--;
                end
                top_scores[pos]  = s;
                top_indices[pos] = IDX_W'(vocab_len);
                if (top_fill < K_MAX)
                    top_fill++;
            end
            vocab_len++;
        end
        if (!is_last)
            return;
        n = vocab_len;
        if (n != 0) begin
            if (beam_on) begin
                k = int'(beam_k);
                if (k < 1)
                    k = 1;
                if (k > K_MAX)
                    k = K_MAX;
                if (n <= k) begin
                    // short vocabulary: whole thing, in arrival order
                    for (int i = 0; i < n && i < K_MAX; i++)
                        queue_word(i, first_scores[i], i + 1 == n);
                end else begin
                    for (int i = 0; i < k && i < top_fill; i++)
                        queue_word(int'(top_indices[i]), top_scores[i], i + 1 == k);
                end
            end else begin
                queue_word(int'(top_indices[0]), top_scores[0], 1'b1);
            end
        end
        vocab_len = 0;
        top_fill  = 0;
    endfunction

    always @(posedge i_clk) begin
        t_token_word got;
        t_token_word want;
        if (!i_rst_n) begin
            beam_on   = 1'b0;
            beam_k    = BEAM_COUNT_RST;
            top_fill  = 0;
            vocab_len = 0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BEAM_MODE:  beam_on = i_cfg_data[0];
                    CFG_BEAM_COUNT: beam_k  = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_score_ch.valid && i_score_ch.ready)
                take_score(i_score_ch.score, i_score_ch.last_score);
            if (i_token_ch.valid && i_token_ch.ready) begin
                got.tok_idx   = i_token_ch.token_index;
                got.tok_score = i_token_ch.token_score;
                got.tok_last  = i_token_ch.last_result;
                words_seen++;
                if (expected_words.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected word idx %0d score %h last %b", $realtime,
                                 got.tok_idx, got.tok_score, got.tok_last);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.tok_idx !== want.tok_idx || got.tok_score !== want.tok_score ||
                        got.tok_last !== want.tok_last) begin
                        if (mismatches < 10)
                            $display("%0t: exp idx %0d score %h last %b, got %0d %h %b",
                                     $realtime, want.tok_idx, want.tok_score, want.tok_last,
                                     got.tok_idx, got.tok_score, got.tok_last);
                        mismatches++;
                    end
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= expected_words.size();
        o_words   <= words_seen;
    end

endmodule

>>> tb/tb_topk_token_selector.sv
`timescale 1ns / 1ps

module tb_topk_token_selector;
    import tks_pkg::*;

    localparam int RUN_LIMIT  = 2_000_000;
    localparam int SETTLE     = 8;
    localparam int RAND_ITEMS = 260;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          cycles        = 0;
    int          n_vocabs      = 0;
    int          n_scores      = 0;
    int unsigned mis_cnt;
    int unsigned pend_cnt;
    int unsigned word_cnt;

    tks_score_if score_ch();
    tks_token_if token_ch();

    topk_token_selector DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_score_ch  (score_ch),
        .o_token_ch  (token_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    tks_selection_checker u_selection_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_score_ch  (score_ch),
        .i_token_ch  (token_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (mis_cnt),
        .o_pending   (pend_cnt),
        .o_words     (word_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        token_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            token_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("FAIL topk_token_selector");
            $finish;
        end
    end

    function automatic logic signed [SCORE_W-1:0] rand_score();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3, 4: begin
                // narrow pool so ties turn up often
                case ($urandom_range(0, 3))
                    0: return 32'sh0001_0000;
                    1: return 32'sh0001_8000;
                    2: return -32'sh0001_0000;
                    default: return -32'sh1;
                endcase
            end
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic send_score(input logic signed [SCORE_W-1:0] s, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            score_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        score_ch.valid      <= 1'b1;
        score_ch.score      <= s;
        score_ch.last_score <= is_last;
        @(posedge i_clk);
        while (!score_ch.ready)
            @(posedge i_clk);
        n_scores++;
        if (is_last)
            n_vocabs++;
    endtask

    task automatic send_vocab(input int len);
        for (int i = 0; i < len; i++)
            send_score(rand_score(), i == len - 1);
    endtask

    // hold the sender until the selector has handed back every word
    task automatic drain();
        score_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pend_cnt != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic configure(input logic mode, input logic [COUNT_W-1:0] count);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BEAM_MODE;
        i_cfg_data  <= CFG_DATA_W'(mode);
        @(posedge i_clk);
        i_cfg_index <= CFG_BEAM_COUNT;
        i_cfg_data  <= count;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_segment(input int goal);
        int sent;
        int len;
        sent = 0;
        while (sent < goal) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 40) : $urandom_range(1, 20);
            send_vocab(len);
            sent += len;
            if ($urandom_range(0, 11) == 0)
                drain();
        end
        drain();
    endtask

    // a segment overshoots its goal by about one vocabulary, hence the small goal
    task automatic run_phase(input int tx_pct, input int rx_pct);
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        configure(1'b0, COUNT_W'($urandom_range(0, 31)));
        run_segment(RAND_ITEMS / 24);
        configure(1'b1, COUNT_W'(16));
        run_segment(RAND_ITEMS / 24);
        configure(1'b1, COUNT_W'(1));
        run_segment(RAND_ITEMS / 24);
        configure(1'b1, COUNT_W'($urandom_range(0, 31)));
        run_segment(RAND_ITEMS / 24);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = CFG_BEAM_MODE;
        i_cfg_data          = '0;
        score_ch.valid      = 1'b0;
        score_ch.score      = '0;
        score_ch.last_score = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: greedy out of reset, tie at the top keeps index 0
        recv_idle_pct = 30;
        send_score(32'sh7FFF_FFFF, 1'b0);
        send_score(32'sh7FFF_FFFF, 1'b0);
        send_score(32'sh8000_0000, 1'b1);
        send_score(32'sh8000_0000, 1'b1);
        drain();

        // beam count 0 behaves as 1
        configure(1'b1, COUNT_W'(0));
        send_score(-32'sh1, 1'b0);
        send_score(32'sh5, 1'b0);
        send_score(32'sh5, 1'b1);
        send_score(32'sh0001_0000, 1'b1);
        drain();

        // count above the list depth clamps; short vocabulary comes back in order
        configure(1'b1, COUNT_W'(31));
        send_score(32'sh8000_0000, 1'b0);
        send_score(32'sh7FFF_FFFF, 1'b0);
        send_score('0, 1'b0);
        send_score(32'sh7FFF_FFFF, 1'b1);
        drain();

        configure(1'b1, COUNT_W'(3));
        send_score(32'sh0001_0000, 1'b0);
        send_score(32'sh0002_0000, 1'b0);
        send_score(32'sh0001_0000, 1'b0);
        send_score(32'sh0002_0000, 1'b0);
        send_score(32'sh7FFF_FFFF, 1'b0);
        send_score(-32'sh1, 1'b1);
        send_score(32'sh5, 1'b0);
        send_score(-32'sh5, 1'b0);
        send_score(32'sh5, 1'b1);
        drain();

        run_phase(19, 87);
        run_phase(87, 19);
        run_phase(0, 0);

        $display("Covered %0d vocabularies, %0d scores, %0d result words checked.",
                 n_vocabs, n_scores, word_cnt);
        $display("Greedy and beam selection, counts 0 to 31, ties, short lists, stalls.");
        if (mis_cnt == 0 && pend_cnt == 0) begin
            $display("PASS topk_token_selector");
        end else begin
            $display("FAIL topk_token_selector");
        end
        $finish;
    end

endmodule
